FILE: rtl/iff_pkg.sv
// ----------------------------------------------------------------------------
// iff_pkg
// Shared types, constants and character helpers of the integer field
// formatter.
// ----------------------------------------------------------------------------
package iff_pkg;

    localparam int NUM_DIGITS = 22;            // enough for 64-bit octal
    localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
    localparam int BODY_SLOTS = 64;            // output byte cap
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_PREC   = 62;
    localparam int DAB_STEPS  = 32;            // two bits per step over 64 bits
    localparam int DAB_CNT_W  = $clog2(DAB_STEPS);

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_X_UP    = 8'h58;
    localparam logic [7:0] CH_X_LOW   = 8'h78;

    typedef enum logic [3:0] {
        CMD_D       = 4'd0,
        CMD_U       = 4'd1,
        CMD_O       = 4'd2,
        CMD_X       = 4'd3,
        CMD_XU      = 4'd4,
        CMD_P       = 4'd5,
        CMD_C       = 4'd6,
        CMD_PERCENT = 4'd7,
        CMD_UNKNOWN = 4'd8
    } t_cmd;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_OCT,
        RADIX_HEX
    } t_radix;

    typedef logic [NUM_DIGITS-1:0][3:0] t_digits;

    typedef struct packed {
        logic [3:0]  command;
        logic        left_align;
        logic        zero_pad;
        logic        plus_sign;
        logic        space_sign;
        logic        alternate_form;
        logic [6:0]  field_width;
        logic [5:0]  precision;
        logic        has_precision;
        logic [2:0]  length_code;
        logic [63:0] arg_value;
        logic [7:0]  literal_char;
    } t_req;

    typedef struct packed {
        logic   start;
        t_radix radix;
    } t_conv_ctl;

    // ascii character of one digit value
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else if (upper) begin
            c = 8'h41 + {4'd0, d - 4'd10};
        end else begin
            c = 8'h61 + {4'd0, d - 4'd10};
        end
        return c;
    endfunction

endpackage

FILE: rtl/iff_if.sv
// ----------------------------------------------------------------------------
// iff_req_if / iff_byte_if
// Valid/ready channels: conversion requests in, text bytes out.
// ----------------------------------------------------------------------------
interface iff_req_if;
    import iff_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface iff_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;
    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

FILE: rtl/iff_conv.sv
// ----------------------------------------------------------------------------
// iff_conv
// Digit converter: octal and hex by bit slicing, decimal by
// shift-and-add-3 over the magnitude, two bits per cycle.
// ----------------------------------------------------------------------------
module iff_conv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iff_pkg::t_conv_ctl i_ctl,
    input  logic [63:0]       i_mag,
    output logic              o_done,
    output iff_pkg::t_digits  o_digits
);
    import iff_pkg::*;

    t_digits             r_digits;
    logic [63:0]         r_bin;
    logic [DAB_CNT_W-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    t_digits             slice;
    t_digits             dab;

    // one shift-and-add-3 step
    function automatic t_digits dab_step(input t_digits b, input logic bit_in);
        t_digits                 a;
        logic [NUM_DIGITS*4-1:0] f;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            a[i] = (b[i] >= 4'd5) ? b[i] + 4'd3 : b[i];
        end
        f = a;
        return {f[NUM_DIGITS*4-2:0], bit_in};
    endfunction

    // direct digit slicing for power-of-two radixes
    always_comb begin
        logic [65:0] ext;
        ext = {2'b00, i_mag};
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (i_ctl.radix == RADIX_OCT) begin
                slice[i] = {1'b0, ext[3*i +: 3]};
            end else if (i < 16) begin
                slice[i] = ext[4*i +: 4];
            end else begin
                slice[i] = 4'd0;
            end
        end
    end

    assign dab = dab_step(dab_step(r_digits, r_bin[63]), r_bin[62]);

    // sequencer of the decimal loop and load of the sliced digits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                if (i_ctl.radix == RADIX_DEC) begin
                    r_digits <= '0;
                    r_bin    <= i_mag;
                    r_cnt    <= '0;
                    r_busy   <= 1'b1;
                end else begin
                    r_digits <= slice;
                    r_done   <= 1'b1;
                end
            end else if (r_busy) begin
                r_digits <= dab;
                r_bin    <= {r_bin[61:0], 2'b00};
                r_cnt    <= r_cnt + 1'b1;
                if (r_cnt == DAB_CNT_W'(DAB_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_digits = r_digits;

endmodule

FILE: rtl/integer_field_formatter.sv
// ----------------------------------------------------------------------------
// integer_field_formatter
// Formats one parsed printf integer conversion into a run of ascii bytes.
// ----------------------------------------------------------------------------
// sequence: idle, conversion (decimal, octal, hex and pointer only), digit
//   count, layout setup, then emit at one byte per cycle while the sink is ready
// requests: a new request is taken only in idle, after the earlier one is
//   done
// reset: synchronous active low, clears the sequencer and output valid
// ----------------------------------------------------------------------------
module integer_field_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iff_req_if.sink     i_req,
    iff_byte_if.source  o_byte
);
    import iff_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_SETUP,
        ST_EMIT
    } t_state;

    t_state       r_state;
    t_conv_ctl    r_ctl;
    logic [63:0]  r_mag;
    logic         r_left, r_zok, r_hasp, r_altoct, r_magzero, r_upper, r_raw;
    logic [1:0]   r_rawlen;
    logic [7:0]   r_raw0, r_raw1;
    logic [7:0]   r_head0, r_head1, r_head2;
    logic [1:0]   r_headlen;
    logic [6:0]   r_width;
    logic [5:0]   r_prec;
    logic [4:0]   r_dlen;
    logic [5:0]   r_zeros;
    logic [6:0]   r_b1, r_b2, r_b4, r_b5, r_total;
    logic [5:0]   r_k;
    logic [7:0]   r_obyte;
    logic         r_olast, r_ovalid;

    logic         conv_done;
    t_digits      digits;
    logic         accept_req, emit_go;

    // request decode
    t_cmd         cmd;
    logic [63:0]  v, mag;
    logic         neg, sgn, pfx, hexk;
    logic [7:0]   sgn_ch, x_ch;

    always_comb begin
        cmd = (i_req.data.command > 4'(CMD_UNKNOWN)) ? CMD_UNKNOWN
                                                     : t_cmd'(i_req.data.command);
        v = i_req.data.arg_value;
        if (i_req.data.length_code <= 3'd2) begin
            v = {{32{(cmd == CMD_D) & v[31]}}, v[31:0]};
        end
        neg  = (cmd == CMD_D) & v[63];
        mag  = neg ? (~v + 64'd1) : v;
        hexk = (cmd == CMD_X) || (cmd == CMD_XU);
        sgn  = (cmd == CMD_D) & (neg | i_req.data.plus_sign | i_req.data.space_sign);
        sgn_ch = neg ? CH_MINUS : (i_req.data.plus_sign ? CH_PLUS : CH_SPACE);
        pfx  = (hexk & i_req.data.alternate_form & (mag != 64'd0)) | (cmd == CMD_P);
        x_ch = (cmd == CMD_XU) ? CH_X_UP : CH_X_LOW;
    end

    iff_conv u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_ctl),
        .i_mag    (r_mag),
        .o_done   (conv_done),
        .o_digits (digits)
    );

    // digit count: highest nonzero digit
    logic [4:0] top_dl;
    always_comb begin
        top_dl = 5'd1;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (digits[i] != 4'd0) begin
                top_dl = 5'(i + 1);
            end
        end
    end

    // length of digits and precision zeros
    logic [4:0] dl_n;
    logic [5:0] zr_n;
    always_comb begin
        dl_n = r_raw ? {3'd0, r_rawlen} : top_dl;
        zr_n = 6'd0;
        if (!r_raw && r_hasp) begin
            if (r_prec == 6'd0 && r_magzero) begin
                dl_n = 5'd0;
            end else if ({1'b0, dl_n} < r_prec) begin
                zr_n = r_prec - {1'b0, dl_n};
            end
        end
        if (r_altoct && zr_n == 6'd0 && !(r_magzero && dl_n == 5'd1)) begin
            zr_n = 6'd1;
        end
    end

    // field layout
    logic [6:0] blen, pad, pl, zp, b1, b2, b3, b4, b5, tot;
    always_comb begin
        blen = {5'd0, r_headlen} + {1'b0, r_zeros} + {2'b0, r_dlen};
        pad  = (r_width > blen) ? r_width - blen : 7'd0;
        tot  = (blen >= 7'(BODY_SLOTS)) ? 7'(BODY_SLOTS) : blen + pad;
        pl   = 7'd0;
        zp   = 7'd0;
        if (!r_left) begin
            if (r_zok) begin
                zp = pad;
            end else begin
                pl = pad;
            end
        end
        b1 = pl;
        b2 = b1 + {5'd0, r_headlen};
        b3 = b2 + zp;
        b4 = b3 + {1'b0, r_zeros};
        b5 = b4 + {2'b0, r_dlen};
    end

    // byte at the current position
    logic [6:0]         kk, hd, dd;
    logic [DIG_IDX_W-1:0] didx;
    logic [7:0]         ch;
    logic               last;
    always_comb begin
        kk   = {1'b0, r_k};
        hd   = kk - r_b1;
        dd   = kk - r_b4;
        didx = DIG_IDX_W'(r_dlen - 5'd1 - dd[4:0]);
        last = (kk + 7'd1 == r_total);
        priority if (kk < r_b1) begin
            ch = CH_SPACE;
        end else if (kk < r_b2) begin
            ch = (hd[1:0] == 2'd0) ? r_head0 : ((hd[1:0] == 2'd1) ? r_head1 : r_head2);
        end else if (kk < r_b4) begin
            ch = CH_ZERO;
        end else if (kk < r_b5) begin
            if (r_raw) begin
                ch = dd[0] ? r_raw1 : r_raw0;
            end else begin
                ch = digit_char(digits[didx], r_upper);
            end
        end else begin
            ch = CH_SPACE;
        end
    end

    assign accept_req = (r_state == ST_IDLE) && i_req.valid;
    assign emit_go    = (r_state == ST_EMIT) && (!r_ovalid || o_byte.ready);

    // sequencer and output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ctl.start <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            // converter start pulse and output word valid
            r_ctl.start <= accept_req && (cmd < CMD_C);
            if (emit_go) begin
                r_ovalid <= 1'b1;
            end else if (o_byte.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_mag     <= (cmd == CMD_P) ? i_req.data.arg_value : mag;
                        r_magzero <= (mag == 64'd0);
                        r_left    <= i_req.data.left_align;
                        r_upper   <= (cmd == CMD_XU);
                        r_prec    <= (i_req.data.precision > 6'(MAX_PREC)) ?
                                     6'(MAX_PREC) : i_req.data.precision;
                        r_width   <= (cmd == CMD_PERCENT) ? 7'd0 :
                                     ((i_req.data.field_width > 7'(MAX_WIDTH)) ?
                                      7'(MAX_WIDTH) : i_req.data.field_width);
                        r_hasp    <= i_req.data.has_precision & (cmd <= CMD_XU);
                        r_altoct  <= i_req.data.alternate_form & (cmd == CMD_O);
                        r_zok     <= i_req.data.zero_pad &
                                     ((cmd == CMD_P) || (cmd == CMD_UNKNOWN) ||
                                      ((cmd <= CMD_XU) && !i_req.data.has_precision));
                        r_head0   <= sgn ? sgn_ch : CH_ZERO;
                        r_head1   <= sgn ? CH_ZERO : x_ch;
                        r_head2   <= x_ch;
                        r_headlen <= {pfx, sgn & !pfx} + {1'b0, sgn & pfx};
                        r_raw     <= (cmd >= CMD_C);
                        r_rawlen  <= (cmd == CMD_UNKNOWN) ? 2'd2 : 2'd1;
                        r_raw0    <= (cmd == CMD_C) ? i_req.data.arg_value[7:0] : CH_PERCENT;
                        r_raw1    <= i_req.data.literal_char;
                        r_ctl.radix <= (cmd == CMD_O) ? RADIX_OCT :
                                       ((cmd <= CMD_U) ? RADIX_DEC : RADIX_HEX);
                        if (cmd >= CMD_C) begin
                            r_state <= ST_COUNT;
                        end else begin
                            r_state <= ST_CONV;
                        end
                    end
                end
                ST_CONV: begin
                    if (conv_done) begin
                        r_state <= ST_COUNT;
                    end
                end
                ST_COUNT: begin
                    r_dlen  <= dl_n;
                    r_zeros <= zr_n;
                    r_state <= ST_SETUP;
                end
                ST_SETUP: begin
                    r_b1    <= b1;
                    r_b2    <= b2;
                    r_b4    <= b4;
                    r_b5    <= b5;
                    r_total <= tot;
                    r_k     <= 6'd0;
                    r_state <= (tot == 7'd0) ? ST_IDLE : ST_EMIT;
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        r_obyte  <= ch;
                        r_olast  <= last;
                        r_k      <= r_k + 6'd1;
                        if (last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_req.ready      = (r_state == ST_IDLE);
    assign o_byte.valid     = r_ovalid;
    assign o_byte.out_byte  = r_obyte;
    assign o_byte.last_byte = r_olast;

endmodule
